FILE: src/bllca_pkg.sv
`default_nettype none
package bllca_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int LOG_LEVELS = 11;

    localparam int NODE_W    = 11;
    localparam int DEP_W     = $clog2(MAX_NODES);
    localparam int LVL_W     = $clog2(LOG_LEVELS);
    localparam int DEP_DEPTH = MAX_NODES + 1;
    localparam int DEP_AW    = $clog2(DEP_DEPTH);
    localparam int ANC_DEPTH = (MAX_NODES + 1) * LOG_LEVELS;
    localparam int ANC_AW    = $clog2(ANC_DEPTH);

    localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LOG_LEVELS - 1);

    localparam logic [4:0] OP_NOP     = 5'd0;
    localparam logic [4:0] OP_CLR     = 5'd1;
    localparam logic [4:0] OP_CAP     = 5'd2;
    localparam logic [4:0] OP_LD_DRD  = 5'd3;
    localparam logic [4:0] OP_LD_WR0  = 5'd4;
    localparam logic [4:0] OP_LD_ARD  = 5'd5;
    localparam logic [4:0] OP_LD_WR   = 5'd6;
    localparam logic [4:0] OP_DA_RD   = 5'd7;
    localparam logic [4:0] OP_DA_SET  = 5'd8;
    localparam logic [4:0] OP_DB_RD   = 5'd9;
    localparam logic [4:0] OP_DB_SET  = 5'd10;
    localparam logic [4:0] OP_X_RD    = 5'd11;
    localparam logic [4:0] OP_CLIMB   = 5'd12;
    localparam logic [4:0] OP_PA_SET  = 5'd13;
    localparam logic [4:0] OP_Y_RD    = 5'd14;
    localparam logic [4:0] OP_LIFT    = 5'd15;
    localparam logic [4:0] OP_P_SET   = 5'd16;
    localparam logic [4:0] OP_P_EQ    = 5'd17;
    localparam logic [4:0] OP_DP_RD   = 5'd18;
    localparam logic [4:0] OP_DP_SET  = 5'd19;
    localparam logic [4:0] OP_SEL     = 5'd20;
    localparam logic [4:0] OP_EMIT    = 5'd21;
    localparam logic [4:0] OP_EMIT_S0 = 5'd22;
    localparam logic [4:0] OP_EMIT_Z  = 5'd23;

    typedef struct packed {
        logic [4:0]       op;
        logic [LVL_W-1:0] lvl;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic in_load;
        logic in_ok;
        logic nodes_eq;
        logic step_beyond;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

FILE: src/bllca_ctrl.sv
`default_nettype none
module bllca_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire bllca_pkg::t_stat i_stat,
    output bllca_pkg::t_cmd    o_cmd
);
    import bllca_pkg::*;

    localparam logic [4:0] ST_CLR     = 5'd0;
    localparam logic [4:0] ST_IDLE    = 5'd1;
    localparam logic [4:0] ST_LD_DRD  = 5'd2;
    localparam logic [4:0] ST_LD_WR0  = 5'd3;
    localparam logic [4:0] ST_LD_ARD  = 5'd4;
    localparam logic [4:0] ST_LD_WR   = 5'd5;
    localparam logic [4:0] ST_QA_RD   = 5'd6;
    localparam logic [4:0] ST_QA_SET  = 5'd7;
    localparam logic [4:0] ST_QB_RD   = 5'd8;
    localparam logic [4:0] ST_QB_SET  = 5'd9;
    localparam logic [4:0] ST_CL1_RD  = 5'd10;
    localparam logic [4:0] ST_CL1_UP  = 5'd11;
    localparam logic [4:0] ST_Q_EQ    = 5'd12;
    localparam logic [4:0] ST_UA_RD   = 5'd13;
    localparam logic [4:0] ST_UA_SET  = 5'd14;
    localparam logic [4:0] ST_UB_RD   = 5'd15;
    localparam logic [4:0] ST_UB_LIFT = 5'd16;
    localparam logic [4:0] ST_P_RD    = 5'd17;
    localparam logic [4:0] ST_P_SET   = 5'd18;
    localparam logic [4:0] ST_DP_RD   = 5'd19;
    localparam logic [4:0] ST_DP_SET  = 5'd20;
    localparam logic [4:0] ST_SEL     = 5'd21;
    localparam logic [4:0] ST_CL2_RD  = 5'd22;
    localparam logic [4:0] ST_CL2_UP  = 5'd23;
    localparam logic [4:0] ST_EMIT    = 5'd24;
    localparam logic [4:0] ST_EMIT_S0 = 5'd25;
    localparam logic [4:0] ST_EMIT_Z  = 5'd26;

    logic [4:0]       r_state, n_state;
    logic [LVL_W-1:0] r_lvl, n_lvl;
    logic [4:0]       op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_lvl   <= '0;
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_lvl      = r_lvl;
        op         = OP_NOP;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLR: begin
                op = OP_CLR;
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    op = OP_CAP;
                    if (i_stat.in_load) begin
                        n_state = i_stat.in_ok ? ST_LD_DRD : ST_IDLE;
                    end else begin
                        n_state = i_stat.in_ok ? ST_QA_RD : ST_EMIT_Z;
                    end
                end
            end
            ST_LD_DRD: begin
                op      = OP_LD_DRD;
                n_state = ST_LD_WR0;
            end
            ST_LD_WR0: begin
                op      = OP_LD_WR0;
                n_lvl   = LVL_W'(1);
                n_state = ST_LD_ARD;
            end
            ST_LD_ARD: begin
                op      = OP_LD_ARD;
                n_state = ST_LD_WR;
            end
            ST_LD_WR: begin
                op = OP_LD_WR;
                if (r_lvl == LVL_LAST) begin
                    n_state = ST_IDLE;
                end else begin
                    n_lvl   = r_lvl + LVL_W'(1);
                    n_state = ST_LD_ARD;
                end
            end
            ST_QA_RD: begin
                op      = OP_DA_RD;
                n_state = ST_QA_SET;
            end
            ST_QA_SET: begin
                op      = OP_DA_SET;
                n_state = ST_QB_RD;
            end
            ST_QB_RD: begin
                op      = OP_DB_RD;
                n_state = ST_QB_SET;
            end
            ST_QB_SET: begin
                op      = OP_DB_SET;
                n_lvl   = '0;
                n_state = ST_CL1_RD;
            end
            ST_CL1_RD: begin
                op      = OP_X_RD;
                n_state = ST_CL1_UP;
            end
            ST_CL1_UP: begin
                op = OP_CLIMB;
                if (r_lvl == LVL_LAST) begin
                    n_state = ST_Q_EQ;
                end else begin
                    n_lvl   = r_lvl + LVL_W'(1);
                    n_state = ST_CL1_RD;
                end
            end
            ST_Q_EQ: begin
                op = OP_P_EQ;
                if (i_stat.nodes_eq) begin
                    n_state = ST_DP_RD;
                end else begin
                    n_lvl   = LVL_LAST;
                    n_state = ST_UA_RD;
                end
            end
            ST_UA_RD: begin
                op      = OP_X_RD;
                n_state = ST_UA_SET;
            end
            ST_UA_SET: begin
                op      = OP_PA_SET;
                n_state = ST_UB_RD;
            end
            ST_UB_RD: begin
                op      = OP_Y_RD;
                n_state = ST_UB_LIFT;
            end
            ST_UB_LIFT: begin
                op = OP_LIFT;
                if (r_lvl == '0) begin
                    n_state = ST_P_RD;
                end else begin
                    n_lvl   = r_lvl - LVL_W'(1);
                    n_state = ST_UA_RD;
                end
            end
            ST_P_RD: begin
                op      = OP_X_RD;
                n_state = ST_P_SET;
            end
            ST_P_SET: begin
                op      = OP_P_SET;
                n_state = ST_DP_RD;
            end
            ST_DP_RD: begin
                op      = OP_DP_RD;
                n_state = ST_DP_SET;
            end
            ST_DP_SET: begin
                op      = OP_DP_SET;
                n_state = ST_SEL;
            end
            ST_SEL: begin
                op    = OP_SEL;
                n_lvl = '0;
                n_state = i_stat.step_beyond ? ST_EMIT_S0 : ST_CL2_RD;
            end
            ST_CL2_RD: begin
                op      = OP_X_RD;
                n_state = ST_CL2_UP;
            end
            ST_CL2_UP: begin
                op = OP_CLIMB;
                if (r_lvl == LVL_LAST) begin
                    n_state = ST_EMIT;
                end else begin
                    n_lvl   = r_lvl + LVL_W'(1);
                    n_state = ST_CL2_RD;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    op      = OP_EMIT;
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT_S0: begin
                if (i_stat.out_free) begin
                    op      = OP_EMIT_S0;
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT_Z: begin
                if (i_stat.out_free) begin
                    op      = OP_EMIT_Z;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cmd.op  = op;
    assign o_cmd.lvl = r_lvl;

endmodule
`default_nettype wire

FILE: src/bllca_dp.sv
`default_nettype none
module bllca_dp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire bllca_pkg::t_cmd         i_cmd,
    output bllca_pkg::t_stat             o_stat,
    input  wire                          i_kind,
    input  wire  [bllca_pkg::NODE_W-1:0] i_first_node,
    input  wire  [bllca_pkg::NODE_W-1:0] i_second_node,
    input  wire  [bllca_pkg::NODE_W-1:0] i_parent_node,
    input  wire  [bllca_pkg::NODE_W-1:0] i_step_count,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [bllca_pkg::NODE_W-1:0] o_common_ancestor,
    output logic [bllca_pkg::NODE_W-1:0] o_path_length,
    output logic [bllca_pkg::NODE_W-1:0] o_step_node
);
    import bllca_pkg::*;

    localparam logic [NODE_W-1:0] NODE_MAX = NODE_W'(MAX_NODES);
    localparam logic [DEP_W-1:0]  DEP_SAT  = DEP_W'(MAX_NODES - 1);

    logic [NODE_W-1:0] anc_mem [ANC_DEPTH];
    logic [DEP_W-1:0]  dep_mem [DEP_DEPTH];

    logic [NODE_W-1:0] r_anc_rd;
    logic [DEP_W-1:0]  r_dep_rd;
    logic [ANC_AW-1:0] r_clr;

    logic [NODE_W-1:0] r_a, r_b, r_par, r_k, r_x, r_y, r_pa, r_p, r_dist;
    logic [DEP_W-1:0]  r_da, r_db, r_l, r_r;

    logic              anc_we, dep_we;
    logic [ANC_AW-1:0] anc_waddr, anc_raddr;
    logic [NODE_W-1:0] anc_wdata;
    logic [DEP_AW-1:0] dep_waddr, dep_raddr;
    logic [DEP_W-1:0]  dep_wdata, dep_new;
    logic [LVL_W-1:0]  lvl_prev;
    logic [NODE_W-1:0] sum;

    function automatic logic [ANC_AW-1:0] anc_addr(input logic [NODE_W-1:0] node,
                                                   input logic [LVL_W-1:0] lvl);
        anc_addr = ANC_AW'(node) * ANC_AW'(LOG_LEVELS) + ANC_AW'(lvl);
    endfunction

    assign lvl_prev = i_cmd.lvl - LVL_W'(1);
    assign sum      = NODE_W'(r_l) + NODE_W'(r_r);
    assign dep_new  = (r_par == '0) ? '0 :
                      (r_dep_rd >= DEP_SAT) ? DEP_SAT : r_dep_rd + DEP_W'(1);

    assign o_stat.clr_last    = (r_clr == ANC_AW'(ANC_DEPTH - 1));
    assign o_stat.in_load     = !i_kind;
    assign o_stat.in_ok       = i_kind ?
        (i_first_node != '0 && i_first_node <= NODE_MAX &&
         i_second_node != '0 && i_second_node <= NODE_MAX) :
        (i_first_node != '0 && i_first_node <= NODE_MAX && i_parent_node <= NODE_MAX);
    assign o_stat.nodes_eq    = (r_x == r_y);
    assign o_stat.step_beyond = (r_k > sum);
    assign o_stat.out_free    = !o_out_valid || i_out_ready;

    always_comb begin
        anc_we    = 1'b0;
        anc_waddr = anc_addr(r_a, i_cmd.lvl);
        anc_wdata = r_anc_rd;
        dep_we    = 1'b0;
        dep_waddr = r_a[DEP_AW-1:0];
        dep_wdata = dep_new;
        anc_raddr = anc_addr(r_x, i_cmd.lvl);
        dep_raddr = r_a[DEP_AW-1:0];
        case (i_cmd.op)
            OP_CLR: begin
                anc_we    = 1'b1;
                anc_waddr = r_clr;
                anc_wdata = '0;
                dep_we    = (r_clr < ANC_AW'(DEP_DEPTH));
                dep_waddr = r_clr[DEP_AW-1:0];
                dep_wdata = '0;
            end
            OP_LD_DRD: dep_raddr = r_par[DEP_AW-1:0];
            OP_LD_WR0: begin
                dep_we    = 1'b1;
                anc_we    = 1'b1;
                anc_waddr = anc_addr(r_a, '0);
                anc_wdata = r_par;
            end
            OP_LD_ARD: anc_raddr = anc_addr(r_x, lvl_prev);
            OP_LD_WR:  anc_we = 1'b1;
            OP_DB_RD:  dep_raddr = r_b[DEP_AW-1:0];
            OP_Y_RD:   anc_raddr = anc_addr(r_y, i_cmd.lvl);
            OP_DP_RD:  dep_raddr = r_p[DEP_AW-1:0];
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (anc_we) anc_mem[anc_waddr] <= anc_wdata;
        if (dep_we) dep_mem[dep_waddr] <= dep_wdata;
        r_anc_rd <= anc_mem[anc_raddr];
        r_dep_rd <= dep_mem[dep_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_CLR) r_clr <= r_clr + ANC_AW'(1);
            if (i_cmd.op == OP_EMIT || i_cmd.op == OP_EMIT_S0 || i_cmd.op == OP_EMIT_Z) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAP: begin
                r_a   <= i_first_node;
                r_b   <= i_second_node;
                r_par <= i_parent_node;
                r_k   <= i_step_count;
            end
            OP_LD_WR0: r_x <= r_par;
            OP_LD_WR:  r_x <= r_anc_rd;
            OP_DA_SET: r_da <= r_dep_rd;
            OP_DB_SET: begin
                r_db <= r_dep_rd;
                if (r_da < r_dep_rd) begin
                    r_x    <= r_b;
                    r_y    <= r_a;
                    r_dist <= NODE_W'(r_dep_rd - r_da);
                end else begin
                    r_x    <= r_a;
                    r_y    <= r_b;
                    r_dist <= NODE_W'(r_da - r_dep_rd);
                end
            end
            OP_CLIMB: if (r_dist[i_cmd.lvl]) r_x <= r_anc_rd;
            OP_PA_SET: r_pa <= r_anc_rd;
            OP_LIFT: begin
                if (r_pa != r_anc_rd) begin
                    r_x <= r_pa;
                    r_y <= r_anc_rd;
                end
            end
            OP_P_SET: r_p <= r_anc_rd;
            OP_P_EQ:  r_p <= r_x;
            OP_DP_SET: begin
                r_l <= (r_da >= r_dep_rd) ? r_da - r_dep_rd : '0;
                r_r <= (r_db >= r_dep_rd) ? r_db - r_dep_rd : '0;
            end
            OP_SEL: begin
                if (r_k <= NODE_W'(r_l)) begin
                    r_x    <= r_a;
                    r_dist <= r_k;
                end else begin
                    r_x    <= r_b;
                    r_dist <= sum - r_k;
                end
            end
            OP_EMIT: begin
                o_common_ancestor <= r_p;
                o_path_length     <= sum;
                o_step_node       <= r_x;
            end
            OP_EMIT_S0: begin
                o_common_ancestor <= r_p;
                o_path_length     <= sum;
                o_step_node       <= '0;
            end
            OP_EMIT_Z: begin
                o_common_ancestor <= '0;
                o_path_length     <= '0;
                o_step_node       <= '0;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: src/binary_lifting_lca_engine.sv
`default_nettype none
// channel  | handshake                    | fields
// in       | i_in_valid / o_in_ready      | kind, first_node, second_node, parent_node, step_count
// out      | o_out_valid / i_out_ready    | common_ancestor, path_length, step_node
//
// load word: a depth table read for the parent, then one ancestor table read per level above level 0
// query word: a climb over every ancestor level; unless the first climb meets, a lift over every level
// from the top down; then, unless the step count is beyond the path, a second climb over every level
// after reset, a clearing pass over all (MAX_NODES + 1) * LOG_LEVELS ancestor entries holds o_in_ready low
// one word at a time; a finished result waits in the output register while
// the next word is taken, and the engine stalls only when a second result is due
module binary_lifting_lca_engine (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire                          i_kind,
    input  wire  [bllca_pkg::NODE_W-1:0] i_first_node,
    input  wire  [bllca_pkg::NODE_W-1:0] i_second_node,
    input  wire  [bllca_pkg::NODE_W-1:0] i_parent_node,
    input  wire  [bllca_pkg::NODE_W-1:0] i_step_count,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [bllca_pkg::NODE_W-1:0] o_common_ancestor,
    output logic [bllca_pkg::NODE_W-1:0] o_path_length,
    output logic [bllca_pkg::NODE_W-1:0] o_step_node
);
    import bllca_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    bllca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bllca_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_kind            (i_kind),
        .i_first_node      (i_first_node),
        .i_second_node     (i_second_node),
        .i_parent_node     (i_parent_node),
        .i_step_count      (i_step_count),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_common_ancestor (o_common_ancestor),
        .o_path_length     (o_path_length),
        .o_step_node       (o_step_node)
    );

endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 100ps

class lca_scoreboard;
    typedef struct {
        logic [10:0] anc;
        logic [10:0] span;
        logic [10:0] step;
    } t_path_result;

    logic [10:0]  anc_tbl [0:1024][0:10];
    logic [9:0]   depth_tbl [0:1024];
    t_path_result expected_paths [$];
    int           errors;

    function new();
        for (int n = 0; n <= 1024; n++) begin
            depth_tbl[n] = '0;
            for (int k = 0; k < 11; k++) anc_tbl[n][k] = '0;
        end
        errors = 0;
    endfunction

    function int climb_up(int node, int hops);
        if (hops > depth_tbl[node]) return 0;
        for (int lvl = 0; lvl < 11; lvl++) begin
            if ((hops >> lvl) & 1) node = anc_tbl[node][lvl];
        end
        return node;
    endfunction

    function int meet_point(int a, int b);
        int t;
        int pa;
        int pb;
        if (depth_tbl[a] < depth_tbl[b]) begin
            t = a; a = b; b = t;
        end
        a = climb_up(a, depth_tbl[a] - depth_tbl[b]);
        if (a == b) return a;
        for (int lvl = 10; lvl >= 0; lvl--) begin
            pa = anc_tbl[a][lvl];
            pb = anc_tbl[b][lvl];
            if (pa != pb) begin
                a = pa; b = pb;
            end
        end
        return anc_tbl[a][0];
    endfunction

    function void note_word(logic kind, int first, int second, int parent, int steps);
        t_path_result r;
        int p;
        int l;
        int rr;
        if (!kind) begin
            if (first < 1 || first > 1024 || parent > 1024) return;
            if (parent == 0) depth_tbl[first] = '0;
            else depth_tbl[first] = (depth_tbl[parent] >= 1023) ? 10'd1023
                                                               : depth_tbl[parent] + 10'd1;
            anc_tbl[first][0] = 11'(parent);
            for (int lvl = 1; lvl < 11; lvl++)
                anc_tbl[first][lvl] = anc_tbl[anc_tbl[first][lvl-1]][lvl-1];
            return;
        end
        if (first < 1 || first > 1024 || second < 1 || second > 1024) begin
            r.anc = '0; r.span = '0; r.step = '0;
        end else begin
            p  = meet_point(first, second);
            l  = int'(depth_tbl[first]) - int'(depth_tbl[p]);
            rr = int'(depth_tbl[second]) - int'(depth_tbl[p]);
            if (l < 0) l = 0;
            if (rr < 0) rr = 0;
            r.anc  = 11'(p);
            r.span = (l + rr > 2047) ? 11'd2047 : 11'(l + rr);
            if (steps > l + rr) r.step = '0;
            else if (steps <= l) r.step = 11'(climb_up(first, steps));
            else r.step = 11'(climb_up(second, l + rr - steps));
        end
        expected_paths = {expected_paths, r};
    endfunction

    function void check_result(logic [10:0] anc, logic [10:0] span, logic [10:0] step);
        t_path_result r;
        if (expected_paths.size() == 0) begin
            $display("%0t: unexpected result anc=%0d span=%0d step=%0d",
                     $time, anc, span, step);
            errors++;
            return;
        end
        r = expected_paths.pop_front();
        if (anc !== r.anc) begin
            $display("%0t: common_ancestor expected %0d actual %0d", $time, r.anc, anc);
            errors++;
        end
        if (span !== r.span) begin
            $display("%0t: path_length expected %0d actual %0d", $time, r.span, span);
            errors++;
        end
        if (step !== r.step) begin
            $display("%0t: step_node expected %0d actual %0d", $time, r.step, step);
            errors++;
        end
    endfunction
endclass

module tb;
    import bllca_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_kind = 1'b0;
    logic [NODE_W-1:0] i_first_node = '0;
    logic [NODE_W-1:0] i_second_node = '0;
    logic [NODE_W-1:0] i_parent_node = '0;
    logic [NODE_W-1:0] i_step_count = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [NODE_W-1:0] o_common_ancestor;
    logic [NODE_W-1:0] o_path_length;
    logic [NODE_W-1:0] o_step_node;

    lca_scoreboard sb = new();
    int  cycles = 0;
    bit  quiet;
    int  loaded [$];

    binary_lifting_lca_engine dut (.*);

    always #10 i_clk = ~i_clk;

    assign quiet = (cycles > 40000 && cycles < 70000);

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2500000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 12);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_common_ancestor, o_path_length, o_step_node);
    end

    task send_word(logic kind, int first, int second, int parent, int steps);
        if (!quiet && $urandom_range(99) < 12) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 12);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_first_node  <= NODE_W'(first);
        i_second_node <= NODE_W'(second);
        i_parent_node <= NODE_W'(parent);
        i_step_count  <= NODE_W'(steps);
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(kind, first, second, parent, steps);
        if (!kind && first >= 1 && first <= 1024 && parent <= 1024) loaded = {loaded, first};
    endtask

    task drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_paths.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function int pick_node();
        if (loaded.size() == 0 || $urandom_range(9) == 0) return $urandom_range(1, 1024);
        return loaded[$urandom_range(loaded.size() - 1)];
    endfunction

    initial begin
        int a;
        int b;
        int p;
        int s;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        send_word(1'b0, 1, 2047, 0, 2047);
        send_word(1'b0, 2, 0, 1, 0);
        send_word(1'b0, 3, 0, 2, 0);
        send_word(1'b0, 4, 0, 1, 0);
        send_word(1'b0, 1024, 0, 3, 0);
        send_word(1'b0, 0, 0, 1, 0);
        send_word(1'b0, 1500, 0, 1, 0);
        send_word(1'b0, 7, 0, 1500, 0);
        send_word(1'b1, 1024, 4, 2047, 0);
        send_word(1'b1, 1024, 4, 0, 3);
        send_word(1'b1, 1024, 4, 0, 4);
        send_word(1'b1, 1024, 4, 0, 5);
        send_word(1'b1, 1024, 1024, 0, 0);
        send_word(1'b1, 0, 1, 0, 0);
        send_word(1'b1, 1, 2047, 0, 0);
        send_word(1'b1, 5, 3, 0, 1);
        send_word(1'b1, 1024, 1, 0, 2047);
        send_word(1'b0, 6, 0, 6, 0);
        send_word(1'b1, 6, 1, 0, 1);
        send_word(1'b0, 2, 0, 1024, 0);
        send_word(1'b1, 2, 4, 0, 2);
        send_word(1'b1, 1024, 2, 0, 3);
        drain();

        for (int i = 0; i < 1830; i++) begin
            if (i == 900) drain();
            s = $urandom_range(99);
            if (s < 40) begin
                a = $urandom_range(1, 1024);
                if (loaded.size() == 0 || $urandom_range(9) == 0) p = 0;
                else if ($urandom_range(1)) p = loaded[loaded.size() - 1];
                else p = loaded[$urandom_range(loaded.size() - 1)];
                send_word(1'b0, a, $urandom_range(2047), p, $urandom_range(2047));
            end else if (s < 48) begin
                send_word(1'b0, $urandom_range(2047), $urandom_range(2047),
                          $urandom_range(2047), $urandom_range(2047));
            end else begin
                if ($urandom_range(9) < 8) begin
                    a = pick_node();
                    b = pick_node();
                end else begin
                    a = $urandom_range(2047);
                    b = $urandom_range(2047);
                end
                if ($urandom_range(3) == 0) s = $urandom_range(2047);
                else s = $urandom_range(30);
                send_word(1'b1, a, b, $urandom_range(2047), s);
            end
        end
        drain();

        if (sb.errors == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule

FILE: binary_lifting_lca_engine.f
src/bllca_pkg.sv
src/bllca_ctrl.sv
src/bllca_dp.sv
src/binary_lifting_lca_engine.sv
bench/tb.sv
